[src/lqe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lqe_pkg: shared constants for the line-to-quad extrude core
// Register map, reset values, coordinate width default and pipeline sizing.
// ----------------------------------------------------------------------------
package lqe_pkg;

  localparam int COORD_WIDTH_DEF = 32;

  // APB register map: one 32-bit register, word index in paddr[2]
  localparam int PADDR_W  = 3;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic [31:0] LINE_WIDTH_RST = 32'd131072;

  // the larger normalized magnitude lies in [2^30, 2^31)
  localparam int NORM_W = 31;
  localparam int ROOT_W = 32;
  localparam int QUOT_W = 32;

  localparam int SQRT_STEPS_PER_STAGE = 2;
  localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS_PER_STAGE;
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES = QUOT_W / DIV_BITS_PER_STAGE;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

endpackage
`default_nettype wire

[src/line_to_quad_extrude_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// line_to_quad_extrude_core: 3D segment to screen-plane quad
// Pipelined offset computation (normalize, squares, root, divide) followed by
// a four-beat vertex emitter.
// ----------------------------------------------------------------------------
// One segment beat in gives four vertex beats out (start+off, end+off,
// start-off, end-off). The result channel carries one vertex per beat. The
// offset pipeline takes a segment every cycle while the tail is empty, and
// otherwise only as the tail sends its last corner; else it holds. The first
// vertex passes through 42 register stages: input, delta, two normalize
// stages, squares, sum, 16 square root stages (two root bits each), multiply
// by the width, rounding term, 16 divide stages (two quotient bits each),
// offset sign, output reg.
// line_width is read live, so write it only while the core is empty.
module line_to_quad_extrude_core #(
  parameter int COORD_WIDTH = lqe_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lqe_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic signed [COORD_WIDTH-1:0]  start_x,
  input  wire logic signed [COORD_WIDTH-1:0]  start_y,
  input  wire logic signed [COORD_WIDTH-1:0]  start_z,
  input  wire logic signed [COORD_WIDTH-1:0]  end_x,
  input  wire logic signed [COORD_WIDTH-1:0]  end_y,
  input  wire logic signed [COORD_WIDTH-1:0]  end_z,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [COORD_WIDTH-1:0]       vert_x,
  output logic signed [COORD_WIDTH-1:0]       vert_y,
  output logic signed [COORD_WIDTH-1:0]       vert_z,
  output logic [1:0]                          corner,
  output logic                                last,
  output logic                                degenerate
);

  localparam int CW  = COORD_WIDTH;
  localparam int DW  = CW + 1;
  localparam int MW  = (CW > lqe_pkg::NORM_W) ? CW : lqe_pkg::NORM_W;
  localparam int NW  = lqe_pkg::NORM_W;
  localparam int RW  = lqe_pkg::ROOT_W;
  localparam int QW  = lqe_pkg::QUOT_W;
  localparam int QB  = $clog2(QW);
  localparam int OW  = QW + 1;
  localparam int SW  = ((CW > OW) ? CW : OW) + 1;
  localparam int SQS = lqe_pkg::SQRT_STAGES;
  localparam int SQK = lqe_pkg::SQRT_STEPS_PER_STAGE;
  localparam int DVS = lqe_pkg::DIV_STAGES;
  localparam int DVK = lqe_pkg::DIV_BITS_PER_STAGE;

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
    logic                 dy_neg;
    logic                 dx_pos;
    logic                 degen;
  } pass_t;

  typedef struct packed { logic v; pass_t c; } in_st_t;
  typedef struct packed { logic v; pass_t c; logic [MW-1:0] ax, ay; } mag_st_t;
  typedef struct packed { logic v; pass_t c; logic [NW-1:0] ax, ay; } nrm_st_t;
  typedef struct packed {
    logic v; pass_t c; logic [NW-1:0] ax, ay; logic [2*NW-1:0] sqx, sqy;
  } sqr_st_t;
  typedef struct packed {
    logic v; pass_t c; logic [NW-1:0] ax, ay; logic [63:0] x, r;
  } rt_st_t;
  typedef struct packed {
    logic v; pass_t c; logic [RW-1:0] len; logic [NW+31:0] prx, pry;
  } mul_st_t;
  typedef struct packed {
    logic v; pass_t c; logic [RW:0] den; logic [63:0] remx, remy;
    logic [QW-1:0] qx, qy;
  } dv_st_t;
  typedef struct packed {
    logic v; pass_t c; logic signed [OW-1:0] ox, oy;
  } tail_st_t;

  logic [31:0] line_width;
  logic        adv;
  logic        out_ok;
  logic [1:0]  beat_cnt;

  in_st_t   s_in;
  mag_st_t  s_mag, s_rsh;
  nrm_st_t  s_nrm;
  sqr_st_t  s_sqr;
  rt_st_t   rt [SQS+1];
  mul_st_t  s_mul;
  dv_st_t   dv [DVS+1];
  tail_st_t s_tail;

  // --------------------------------------------------------------------------
  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[lqe_pkg::REG_IDX_LSB] == lqe_pkg::REG_LINE_WIDTH) ? line_width : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= lqe_pkg::LINE_WIDTH_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[lqe_pkg::REG_IDX_LSB] == lqe_pkg::REG_LINE_WIDTH) begin
      line_width <= pwdata;
    end
  end

  // whole pipeline moves together, bubbles included; an empty tail frees it
  assign out_ok   = !out_valid || out_ready;
  assign adv      = !s_tail.v || (out_ok && beat_cnt == lqe_pkg::CORNER_LAST);
  assign in_ready = adv;

  // --------------------------------------------------------------------------
  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_in.v <= 1'b0;
    end else if (adv) begin
      s_in.v      <= in_valid;
      s_in.c.sx   <= start_x;
      s_in.c.sy   <= start_y;
      s_in.c.sz   <= start_z;
      s_in.c.ex   <= end_x;
      s_in.c.ey   <= end_y;
      s_in.c.ez   <= end_z;
      s_in.c.dy_neg <= 1'b0;
      s_in.c.dx_pos <= 1'b0;
      s_in.c.degen  <= 1'b0;
    end
  end

  // delta and magnitudes
  mag_st_t mag_next;
  always_comb begin : c_mag
    logic signed [DW-1:0] dx, dy, nx, ny;
    dx = DW'(s_in.c.ex) - DW'(s_in.c.sx);
    dy = DW'(s_in.c.ey) - DW'(s_in.c.sy);
    nx = -dx;
    ny = -dy;
    mag_next          = '0;
    mag_next.v        = s_in.v;
    mag_next.c        = s_in.c;
    mag_next.c.dy_neg = dy[DW-1];
    mag_next.c.dx_pos = !dx[DW-1] && (dx != '0);
    mag_next.c.degen  = (dx == '0) && (dy == '0);
    mag_next.ax = MW'(dx[DW-1] ? nx[CW-1:0] : dx[CW-1:0]);
    mag_next.ay = MW'(dy[DW-1] ? ny[CW-1:0] : dy[CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_mag.v <= 1'b0;
    end else if (adv) begin
      s_mag <= mag_next;
    end
  end

  // normalize down: bring max below 2^31, truncating both
  mag_st_t rsh_next;
  always_comb begin : c_rsh
    logic [MW-1:0] m;
    rsh_next = s_mag;
    m = (s_mag.ax > s_mag.ay) ? s_mag.ax : s_mag.ay;
    for (int i = 4; i >= 0; i--) begin
      if ((m >> (NW - 1 + (1 << i))) != '0) begin
        m           = m >> (1 << i);
        rsh_next.ax = rsh_next.ax >> (1 << i);
        rsh_next.ay = rsh_next.ay >> (1 << i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_rsh.v <= 1'b0;
    end else if (adv) begin
      s_rsh <= rsh_next;
    end
  end

  // normalize up: max into [2^30, 2^31)
  nrm_st_t nrm_next;
  always_comb begin : c_lsh
    logic [NW-1:0] m, ax, ay;
    ax = s_rsh.ax[NW-1:0];
    ay = s_rsh.ay[NW-1:0];
    m  = (ax > ay) ? ax : ay;
    for (int i = 4; i >= 0; i--) begin
      if ((m >> (NW - (1 << i))) == '0) begin
        m  = m << (1 << i);
        ax = ax << (1 << i);
        ay = ay << (1 << i);
      end
    end
    nrm_next.v  = s_rsh.v;
    nrm_next.c  = s_rsh.c;
    nrm_next.ax = ax;
    nrm_next.ay = ay;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_nrm.v <= 1'b0;
    end else if (adv) begin
      s_nrm <= nrm_next;
    end
  end

  // squares
  always_ff @(posedge clk) begin
    if (rst) begin
      s_sqr.v <= 1'b0;
    end else if (adv) begin
      s_sqr.v   <= s_nrm.v;
      s_sqr.c   <= s_nrm.c;
      s_sqr.ax  <= s_nrm.ax;
      s_sqr.ay  <= s_nrm.ay;
      s_sqr.sqx <= (2*NW)'(s_nrm.ax) * (2*NW)'(s_nrm.ax);
      s_sqr.sqy <= (2*NW)'(s_nrm.ay) * (2*NW)'(s_nrm.ay);
    end
  end

  // radicand
  always_ff @(posedge clk) begin
    if (rst) begin
      rt[0].v <= 1'b0;
    end else if (adv) begin
      rt[0].v  <= s_sqr.v;
      rt[0].c  <= s_sqr.c;
      rt[0].ax <= s_sqr.ax;
      rt[0].ay <= s_sqr.ay;
      rt[0].x  <= 64'(s_sqr.sqx) + 64'(s_sqr.sqy);
      rt[0].r  <= '0;
    end
  end

  // integer square root, SQK result bits per stage
  for (genvar st = 0; st < SQS; st++) begin : g_root
    rt_st_t rt_next;
    always_comb begin : c_root
      logic [63:0] b, t;
      rt_next = rt[st];
      for (int k = 0; k < SQK; k++) begin
        b = 64'(1) << (62 - 2 * (st * SQK + k));
        t = rt_next.r + b;
        if (rt_next.x >= t) begin
          rt_next.x = rt_next.x - t;
          rt_next.r = (rt_next.r >> 1) + b;
        end else begin
          rt_next.r = rt_next.r >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt[st+1].v <= 1'b0;
      end else if (adv) begin
        rt[st+1] <= rt_next;
      end
    end
  end

  // numerators: x offset scales ay, y offset scales ax
  always_ff @(posedge clk) begin
    if (rst) begin
      s_mul.v <= 1'b0;
    end else if (adv) begin
      s_mul.v   <= rt[SQS].v;
      s_mul.c   <= rt[SQS].c;
      s_mul.len <= rt[SQS].r[RW-1:0];
      s_mul.prx <= (NW+32)'(rt[SQS].ay) * (NW+32)'(line_width);
      s_mul.pry <= (NW+32)'(rt[SQS].ax) * (NW+32)'(line_width);
    end
  end

  // rounding term and divisor 2*len
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].v <= 1'b0;
    end else if (adv) begin
      dv[0].v    <= s_mul.v;
      dv[0].c    <= s_mul.c;
      dv[0].den  <= {s_mul.len, 1'b0};
      dv[0].remx <= 64'(s_mul.prx) + 64'(s_mul.len);
      dv[0].remy <= 64'(s_mul.pry) + 64'(s_mul.len);
      dv[0].qx   <= '0;
      dv[0].qy   <= '0;
    end
  end

  // restoring divide, DVK quotient bits per stage, both offsets in parallel
  for (genvar st = 0; st < DVS; st++) begin : g_div
    dv_st_t dv_next;
    always_comb begin : c_div
      logic [64:0]   dsh;
      logic [QB-1:0] g;
      dv_next = dv[st];
      for (int k = 0; k < DVK; k++) begin
        g   = QB'(QW - 1 - (st * DVK + k));
        dsh = 65'(dv_next.den) << g;
        if (65'(dv_next.remx) >= dsh) begin
          dv_next.remx  = dv_next.remx - dsh[63:0];
          dv_next.qx[g] = 1'b1;
        end
        if (65'(dv_next.remy) >= dsh) begin
          dv_next.remy  = dv_next.remy - dsh[63:0];
          dv_next.qy[g] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[st+1].v <= 1'b0;
      end else if (adv) begin
        dv[st+1] <= dv_next;
      end
    end
  end

  // signed offsets
  tail_st_t tail_next;
  always_comb begin : c_tail
    logic signed [OW-1:0] mx, my;
    mx = {1'b0, dv[DVS].qx};
    my = {1'b0, dv[DVS].qy};
    tail_next.v  = dv[DVS].v;
    tail_next.c  = dv[DVS].c;
    tail_next.ox = dv[DVS].c.degen ? '0 : (dv[DVS].c.dy_neg ? -mx : mx);
    tail_next.oy = dv[DVS].c.degen ? '0 : (dv[DVS].c.dx_pos ? -my : my);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_tail.v <= 1'b0;
    end else if (adv) begin
      s_tail <= tail_next;
    end
  end

  // --------------------------------------------------------------------------
  // four-beat vertex emitter
  function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = v;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end
    return r[CW-1:0];
  endfunction

  logic signed [SW-1:0] bx, by, sum_x, sum_y;
  logic signed [CW-1:0] bz;

  always_comb begin
    bx    = SW'(beat_cnt[0] ? s_tail.c.ex : s_tail.c.sx);
    by    = SW'(beat_cnt[0] ? s_tail.c.ey : s_tail.c.sy);
    bz    = beat_cnt[0] ? s_tail.c.ez : s_tail.c.sz;
    sum_x = beat_cnt[1] ? bx - SW'(s_tail.ox) : bx + SW'(s_tail.ox);
    sum_y = beat_cnt[1] ? by - SW'(s_tail.oy) : by + SW'(s_tail.oy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      beat_cnt  <= lqe_pkg::CORNER_FIRST;
    end else if (out_ok) begin
      out_valid <= s_tail.v;
      if (s_tail.v) begin
        beat_cnt <= beat_cnt + 2'd1;
      end
    end
    if (out_ok && s_tail.v) begin
      vert_x     <= sat(sum_x);
      vert_y     <= sat(sum_y);
      vert_z     <= bz;
      corner     <= beat_cnt;
      last       <= (beat_cnt == lqe_pkg::CORNER_LAST);
      degenerate <= s_tail.c.degen;
    end
  end

`ifndef ASSERT_OFF
  // corners of one quad come out in order
  a_corner_seq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && corner == $past(corner) + 2'd1)
    else $error("corner sequence broken");

  // a new quad starts at the first corner
  a_quad_start: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> !out_valid || corner == lqe_pkg::CORNER_FIRST)
    else $error("quad does not restart at first corner");

  // flag is per segment, constant over its four corners
  a_degen_const: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> degenerate == $past(degenerate))
    else $error("degenerate flag changed inside a quad");

  // input is held off while the tail still has corners to send
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready && s_tail.v |-> out_ok && beat_cnt == lqe_pkg::CORNER_LAST)
    else $error("pipeline advanced over an unsent quad");
`endif

endmodule
`default_nettype wire

[sim/line_to_quad_extrude_core_test.sv]
// ----------------------------------------------------------------------------
// line_to_quad_extrude_core_test: self-checking bench for the extrude core
// Drives segments through valid/ready with random gaps, writes line_width over
// APB between phases, predicts the four corners of each quad and checks every
// vertex beat in order.
// ----------------------------------------------------------------------------
module line_to_quad_extrude_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 32;
  localparam int LATENCY = 42;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, sz, ex, ey, ez;
  } segment_t;

  typedef struct packed {
    logic signed [CW-1:0] x, y, z;
    logic [1:0] corner;
    logic last;
    logic degen;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [lqe_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [CW-1:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] vert_x, vert_y, vert_z;
  logic [1:0] corner;
  logic last, degenerate;

  line_to_quad_extrude_core #(.COORD_WIDTH(CW)) uut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  logic [31:0] width_q = lqe_pkg::LINE_WIDTH_RST;
  vertex_t pending_verts[$];
  int errors = 0;
  int seg_count = 0;
  int vert_count = 0;
  int degen_count = 0;
  longint cycles = 0;
  bit stall_rx = 1'b0;

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[CW-1:0];
  endfunction

  task automatic predict_quad(segment_t s);
    longint sx, sy, ex, ey, dx, dy, ox, oy, bx, by;
    logic [63:0] ax, ay, m, len, mx, my;
    bit dg;
    vertex_t v;
    sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey;
    dx = ex - sx;
    dy = ey - sy;
    ox = 0; oy = 0;
    dg = (dx == 0 && dy == 0);
    if (!dg) begin
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      m = ax > ay ? ax : ay;
      while (m >= 64'd1 << 31) begin ax >>= 1; ay >>= 1; m >>= 1; end
      while (m < 64'd1 << 30) begin ax <<= 1; ay <<= 1; m <<= 1; end
      len = isqrt(ax * ax + ay * ay);
      mx = (ay * width_q + len) / (2 * len);
      my = (ax * width_q + len) / (2 * len);
      ox = dy < 0 ? -longint'(mx) : longint'(mx);
      oy = dx > 0 ? -longint'(my) : longint'(my);
    end
    for (int k = 0; k < 4; k++) begin
      bx = k[0] ? ex : sx;
      by = k[0] ? ey : sy;
      v.x = clamp(k[1] ? bx - ox : bx + ox);
      v.y = clamp(k[1] ? by - oy : by + oy);
      v.z = k[0] ? s.ez : s.sz;
      v.corner = k[1:0];
      v.last = (k == 3);
      v.degen = dg;
      pending_verts.push_back(v);
    end
  endtask

  task automatic apb_write(logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= lqe_pkg::PADDR_W'(lqe_pkg::REG_LINE_WIDTH) << lqe_pkg::REG_IDX_LSB;
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    width_q = val;
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // valid stays up across back-to-back beats; a drawn gap drops it first
  task automatic send_segment(segment_t s);
    int gap;
    gap = $urandom_range(0, 3);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    {start_x, start_y, start_z, end_x, end_y, end_z} <= s;
    do @(posedge clk); while (!in_ready);
    predict_quad(s);
    seg_count++;
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 4095) - 2048;
      default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
    endcase
  endfunction

  // directed rows
  localparam int N_DIR = 12;
  segment_t dir_tab[N_DIR];
  bit dir_known[N_DIR];
  vertex_t dir_exp0[N_DIR];

  initial begin
    segment_t s;
    dir_tab[0] = '{32'sd0, 32'sd0, 32'sd5, 32'sd65536, 32'sd0, -32'sd5};
    dir_tab[1] = '{32'sd100, 32'sd200, 32'sd1, 32'sd100, 32'sd200, 32'sd2};
    dir_tab[2] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                   32'sh80000000, 32'sh80000000, 32'sh80000000};
    dir_tab[3] = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
                   32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    dir_tab[4] = '{32'sh7fffffff, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sd1, 32'sd0};
    dir_tab[5] = '{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0, 32'sd0};
    dir_tab[6] = '{32'sd0, 32'sd0, 32'sd0, -32'sd1, -32'sd1, 32'sd0};
    dir_tab[7] = '{32'sh80000000, 32'sh80000000, 32'sd0,
                   32'sh80000000, 32'sh80000000, 32'sd0};
    dir_tab[8] = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0};
    dir_tab[9] = '{-32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0};
    dir_tab[10] = '{32'sh80000000, 32'sd0, 32'sd0, 32'sh7fffffff, 32'sd0, 32'sd0};
    dir_tab[11] = '{32'sd0, 32'sh7fffffff, 32'sd0, 32'sd0, 32'sh80000000, 32'sd0};
    foreach (dir_known[i]) dir_known[i] = 1'b0;
    // unit x step at width 2.0: offset is (0,-1.0)
    dir_known[0] = 1'b1;
    dir_exp0[0] = '{32'sd0, -32'sd65536, 32'sd5, 2'd0, 1'b0, 1'b0};
    // zero delta: corners sit on the endpoints, flagged
    dir_known[1] = 1'b1;
    dir_exp0[1] = '{32'sd100, 32'sd200, 32'sd1, 2'd0, 1'b0, 1'b1};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIR; i++) begin
      send_segment(dir_tab[i]);
      if (dir_known[i] && pending_verts.size() >= 4) begin
        vertex_t p;
        p = pending_verts[pending_verts.size() - 4];
        if (p != dir_exp0[i]) begin
          $error("row %0d: typed corner 0 %p, predicted %p", i, dir_exp0[i], p);
          errors++;
        end
      end
    end
    drain();

    // zero width, then extremes, random widths and the reset width
    for (int ph = 0; ph < 6; ph++) begin
      logic [31:0] w;
      case (ph)
        0: w = 32'd0;
        1: w = 32'hffffffff;
        2: w = 32'd1;
        3: w = $urandom();
        4: w = $urandom_range(1, 32'h00080000);
        default: w = lqe_pkg::LINE_WIDTH_RST;
      endcase
      apb_write(w);
      for (int n = 0; n < 60; n++) begin
        int mode;
        mode = $urandom_range(0, 2);
        s.sx = rand_coord(mode); s.sy = rand_coord(mode); s.sz = $urandom();
        s.ex = rand_coord(mode); s.ey = rand_coord(mode); s.ez = $urandom();
        if ($urandom_range(0, 15) == 0) begin
          s.ex = s.sx; s.ey = s.sy;
        end else if ($urandom_range(0, 7) == 0) begin
          s.ex = s.sx + $urandom_range(0, 2) - 1;
          s.ey = s.sy + $urandom_range(0, 2) - 1;
        end
        send_segment(s);
        if (n == 30) begin
          idle_input();
          while (pending_verts.size() != 0) @(posedge clk);
        end
        if (n >= 40 && n < 50) stall_rx = 1'b0;
        else stall_rx = 1'b1;
      end
      drain();
    end

    $display("covered %0d segments, %0d vertex beats (%0d degenerate), widths 0..max",
             seg_count, vert_count, degen_count);
    if (errors == 0)
      $display("line_to_quad_extrude_core_test: done, clean");
    else
      $display("line_to_quad_extrude_core_test: done, errors");
    $finish;
  end

  // receiver: random back-pressure, with unstalled stretches
  int rx_wait = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (!stall_rx) begin
      out_ready <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (out_valid && out_ready) rx_wait <= $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("line_to_quad_extrude_core_test: done, errors");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      vertex_t e;
      vert_count++;
      if (degenerate) degen_count++;
      if (pending_verts.size() == 0) begin
        $error("vertex beat with nothing expected");
        errors++;
      end else begin
        e = pending_verts.pop_front();
        if (vert_x !== e.x) begin
          $error("vert_x: expected %0d, got %0d", e.x, vert_x); errors++;
        end
        if (vert_y !== e.y) begin
          $error("vert_y: expected %0d, got %0d", e.y, vert_y); errors++;
        end
        if (vert_z !== e.z) begin
          $error("vert_z: expected %0d, got %0d", e.z, vert_z); errors++;
        end
        if (corner !== e.corner) begin
          $error("corner: expected %0d, got %0d", e.corner, corner); errors++;
        end
        if (last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, last); errors++;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate: expected %0d, got %0d", e.degen, degenerate); errors++;
        end
      end
    end
  end

endmodule

[sim.f]
src/lqe_pkg.sv
src/line_to_quad_extrude_core.sv
sim/line_to_quad_extrude_core_test.sv
